@@ hdl/lvfd_pkg.sv @@
// Shared types and constants for the local variance focus depth map block.
package lvfd_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int FRAME_W = 16;
    localparam int IDX_W = 21;
    localparam int VAR_W = 23;
    localparam int WIN = 3;
    localparam int COLSUM_W = 10;
    localparam int COLSQ_W = 18;
    localparam int SUM_W = 12;
    localparam int SQ_W = 20;
    localparam int PROD_W = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;
    localparam int FIFO_CW = 3;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_COLS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROWS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_W-1:0] COLS_RESET = 12'd1388;
    localparam logic [CFG_W-1:0] ROWS_RESET = 12'd1040;
    localparam logic [FRAME_W-1:0] FIRST_RESET = 16'd1;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]   pixel_index;
        logic [VAR_W-1:0]   variance_scaled;
        logic [FRAME_W-1:0] best_frame;
        logic               frame_last;
    } out_word_t;

    typedef struct packed {
        logic emit;
        logic end_row;
        logic end_frame;
        logic left_zero;
        logic top_zero;
    } item_flags_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum_all;
        logic [SQ_W-1:0]  sq_all;
        logic [SUM_W-1:0] sum_right;
        logic [SQ_W-1:0]  sq_right;
    } win_sums_t;

    typedef struct packed {
        logic [VAR_W-1:0]   variance;
        logic [FRAME_W-1:0] frame;
    } best_entry_t;

endpackage

@@ hdl/lvfd_window.sv @@
// Line buffer memory, 3x3 window registers and window sums (stages one and two).
module lvfd_window #(
    parameter int MAX_COLS = 2048,
    parameter int LINW = 23
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          restart,
    input  logic                          in_valid,
    input  logic [$clog2(MAX_COLS)-1:0]   in_col,
    input  logic [lvfd_pkg::PIX_W-1:0]    in_pixel,
    input  lvfd_pkg::item_flags_t         in_flags,
    input  logic [LINW-1:0]               in_lin,
    output logic                          out_valid,
    output lvfd_pkg::item_flags_t         out_flags,
    output logic [LINW-1:0]               out_lin,
    output lvfd_pkg::win_sums_t           out_sums
);

    localparam int CAW = $clog2(MAX_COLS);
    localparam int PW = lvfd_pkg::PIX_W;
    localparam int WIN = lvfd_pkg::WIN;

    logic [2*PW-1:0] line_mem [MAX_COLS];
    logic [2*PW-1:0] line_rd_reg;

    logic                  s1_valid_reg;
    logic [CAW-1:0]        s1_col_reg;
    logic [PW-1:0]         s1_pixel_reg;
    lvfd_pkg::item_flags_t s1_flags_reg;
    logic [LINW-1:0]       s1_lin_reg;

    logic [PW-1:0] win_reg [WIN][WIN];
    logic [PW-1:0] win_next [WIN][WIN];

    logic [lvfd_pkg::COLSUM_W-1:0] col_sum [WIN];
    logic [lvfd_pkg::COLSQ_W-1:0]  col_sq [WIN];
    lvfd_pkg::win_sums_t           sums;

    logic                  s2_valid_reg;
    lvfd_pkg::item_flags_t s2_flags_reg;
    logic [LINW-1:0]       s2_lin_reg;
    lvfd_pkg::win_sums_t   s2_sums_reg;

    // The upper byte holds the row two above, the lower byte the row above.
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= {line_rd_reg[PW-1:0], s1_pixel_reg};
        end
        if (adv && in_valid)
        begin
            line_rd_reg <= line_mem[in_col];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg   <= in_col;
            s1_pixel_reg <= in_pixel;
            s1_flags_reg <= in_flags;
            s1_lin_reg   <= in_lin;
            s2_flags_reg <= s1_flags_reg;
            s2_lin_reg   <= s1_lin_reg;
            s2_sums_reg  <= sums;
        end
    end

    always_comb
    begin
        for (int r = 0; r < WIN; r++)
        begin
            for (int k = 0; k < WIN - 1; k++)
            begin
                win_next[r][k] = win_reg[r][k+1];
            end
        end
        win_next[0][WIN-1] = line_rd_reg[2*PW-1:PW];
        win_next[1][WIN-1] = line_rd_reg[PW-1:0];
        win_next[2][WIN-1] = s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int k = 0; k < WIN; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (restart)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int k = 0; k < WIN; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (adv && s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // The top window row stands outside the image on the first image row.
    always_comb
    begin
        for (int k = 0; k < WIN; k++)
        begin
            col_sum[k] = '0;
            col_sq[k]  = '0;
            for (int r = 0; r < WIN; r++)
            begin
                if (!(r == 0 && s1_flags_reg.top_zero))
                begin
                    col_sum[k] = col_sum[k] + lvfd_pkg::COLSUM_W'(win_next[r][k]);
                    col_sq[k]  = col_sq[k]
                               + lvfd_pkg::COLSQ_W'(16'(win_next[r][k]) * 16'(win_next[r][k]));
                end
            end
        end
    end

    always_comb
    begin
        sums.sum_right = lvfd_pkg::SUM_W'(col_sum[1]) + lvfd_pkg::SUM_W'(col_sum[2]);
        sums.sq_right  = lvfd_pkg::SQ_W'(col_sq[1]) + lvfd_pkg::SQ_W'(col_sq[2]);
        if (s1_flags_reg.left_zero)
        begin
            sums.sum_all = sums.sum_right;
            sums.sq_all  = sums.sq_right;
        end
        else
        begin
            sums.sum_all = sums.sum_right + lvfd_pkg::SUM_W'(col_sum[0]);
            sums.sq_all  = sums.sq_right + lvfd_pkg::SQ_W'(col_sq[0]);
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_flags = s2_flags_reg;
    assign out_lin   = s2_lin_reg;
    assign out_sums  = s2_sums_reg;

endmodule

@@ hdl/lvfd_best.sv @@
// Variance arithmetic and the banked best-variance store with read-modify-write.
module lvfd_best #(
    parameter int MAX_PIXELS = 2097152,
    parameter int LINW = 23
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              stack_restart,
    input  logic [lvfd_pkg::FRAME_W-1:0]      first_index,
    input  logic                              in_valid,
    input  lvfd_pkg::item_flags_t             in_flags,
    input  logic [LINW-1:0]                   in_lin,
    input  lvfd_pkg::win_sums_t               in_sums,
    output logic                              push0,
    output logic                              push1,
    output lvfd_pkg::out_word_t               word0,
    output lvfd_pkg::out_word_t               word1
);

    localparam int PAW = $clog2(MAX_PIXELS);
    localparam int BANK_AW = PAW - 1;
    localparam int BANK_DEPTH = MAX_PIXELS / 2;
    localparam int VW = lvfd_pkg::VAR_W;
    localparam int FW = lvfd_pkg::FRAME_W;
    localparam int PRW = lvfd_pkg::PROD_W;

    lvfd_pkg::best_entry_t ev_mem [BANK_DEPTH];
    lvfd_pkg::best_entry_t od_mem [BANK_DEPTH];

    logic [LINW-1:0]    lin2;
    logic [BANK_AW-1:0] ev_addr;
    logic [BANK_AW-1:0] od_addr;
    logic [PRW-1:0]     nine_sq_all;
    logic [PRW-1:0]     nine_sq_right;
    logic [PRW-1:0]     sum_sq_all;
    logic [PRW-1:0]     sum_sq_right;
    logic [PRW-1:0]     var_all;
    logic [PRW-1:0]     var_right;

    logic                  s3_valid_reg;
    lvfd_pkg::item_flags_t s3_flags_reg;
    logic [LINW-1:0]       s3_lin_reg;
    logic [VW-1:0]         s3_var1_reg;
    logic [VW-1:0]         s3_var2_reg;
    logic [BANK_AW-1:0]    s3_ev_addr_reg;
    logic [BANK_AW-1:0]    s3_od_addr_reg;

    lvfd_pkg::best_entry_t ev_rd_reg;
    lvfd_pkg::best_entry_t od_rd_reg;
    logic                  ev_fwd_reg;
    logic                  od_fwd_reg;
    lvfd_pkg::best_entry_t ev_fwd_data_reg;
    lvfd_pkg::best_entry_t od_fwd_data_reg;

    logic [FW-1:0] frame_count_reg;
    logic [FW-1:0] frame_count_next;
    logic          first_frame_reg;
    logic          first_frame_next;

    lvfd_pkg::best_entry_t ev_cur;
    lvfd_pkg::best_entry_t od_cur;
    lvfd_pkg::best_entry_t old1;
    lvfd_pkg::best_entry_t old2;
    lvfd_pkg::best_entry_t new1;
    lvfd_pkg::best_entry_t new2;
    lvfd_pkg::best_entry_t ev_wdata;
    lvfd_pkg::best_entry_t od_wdata;
    logic                  has1;
    logic                  has2;
    logic                  ev_we;
    logic                  od_we;
    logic [LINW-1:0]       s3_lin2;

    assign nine_sq_all   = PRW'({in_sums.sq_all, 3'b000}) + PRW'(in_sums.sq_all);
    assign nine_sq_right = PRW'({in_sums.sq_right, 3'b000}) + PRW'(in_sums.sq_right);
    assign sum_sq_all    = PRW'(in_sums.sum_all) * PRW'(in_sums.sum_all);
    assign sum_sq_right  = PRW'(in_sums.sum_right) * PRW'(in_sums.sum_right);
    assign var_all       = nine_sq_all - sum_sq_all;
    assign var_right     = nine_sq_right - sum_sq_right;

    // The two results of a row end fall on consecutive addresses, one in each bank.
    assign lin2    = in_lin + LINW'(1);
    assign ev_addr = in_lin[0] ? lin2[PAW-1:1] : in_lin[PAW-1:1];
    assign od_addr = in_lin[0] ? in_lin[PAW-1:1] : lin2[PAW-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            ev_fwd_reg   <= 1'b0;
            od_fwd_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= in_valid;
            ev_fwd_reg   <= ev_we && (s3_ev_addr_reg == ev_addr);
            od_fwd_reg   <= od_we && (s3_od_addr_reg == od_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_flags_reg    <= in_flags;
            s3_lin_reg      <= in_lin;
            s3_var1_reg     <= var_all[VW-1:0];
            s3_var2_reg     <= var_right[VW-1:0];
            s3_ev_addr_reg  <= ev_addr;
            s3_od_addr_reg  <= od_addr;
            ev_fwd_data_reg <= ev_wdata;
            od_fwd_data_reg <= od_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_we)
        begin
            ev_mem[s3_ev_addr_reg] <= ev_wdata;
        end
        if (adv)
        begin
            ev_rd_reg <= ev_mem[ev_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (od_we)
        begin
            od_mem[s3_od_addr_reg] <= od_wdata;
        end
        if (adv)
        begin
            od_rd_reg <= od_mem[od_addr];
        end
    end

    always_comb
    begin
        ev_cur = ev_fwd_reg ? ev_fwd_data_reg : ev_rd_reg;
        od_cur = od_fwd_reg ? od_fwd_data_reg : od_rd_reg;
        old1   = s3_lin_reg[0] ? od_cur : ev_cur;
        old2   = s3_lin_reg[0] ? ev_cur : od_cur;
        if (first_frame_reg || s3_var1_reg > old1.variance)
        begin
            new1.variance = s3_var1_reg;
            new1.frame    = frame_count_reg;
        end
        else
        begin
            new1 = old1;
        end
        if (first_frame_reg || s3_var2_reg > old2.variance)
        begin
            new2.variance = s3_var2_reg;
            new2.frame    = frame_count_reg;
        end
        else
        begin
            new2 = old2;
        end
        has1     = s3_valid_reg && s3_flags_reg.emit;
        has2     = has1 && s3_flags_reg.end_row;
        ev_we    = adv && (s3_lin_reg[0] ? has2 : has1);
        od_we    = adv && (s3_lin_reg[0] ? has1 : has2);
        ev_wdata = s3_lin_reg[0] ? new2 : new1;
        od_wdata = s3_lin_reg[0] ? new1 : new2;
    end

    assign s3_lin2 = s3_lin_reg + LINW'(1);
    assign push0 = adv && has1;
    assign push1 = adv && has2;

    always_comb
    begin
        word0.pixel_index     = s3_lin_reg[lvfd_pkg::IDX_W-1:0];
        word0.variance_scaled = s3_var1_reg;
        word0.best_frame      = new1.frame;
        word0.frame_last      = 1'b0;
        word1.pixel_index     = s3_lin2[lvfd_pkg::IDX_W-1:0];
        word1.variance_scaled = s3_var2_reg;
        word1.best_frame      = new2.frame;
        word1.frame_last      = s3_flags_reg.end_frame;
    end

    always_comb
    begin
        frame_count_next = frame_count_reg;
        first_frame_next = first_frame_reg;
        if (stack_restart)
        begin
            frame_count_next = first_index;
            first_frame_next = 1'b1;
        end
        else if (adv && s3_valid_reg && s3_flags_reg.end_frame)
        begin
            frame_count_next = frame_count_reg + FW'(1);
            first_frame_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= lvfd_pkg::FIRST_RESET;
            first_frame_reg <= 1'b1;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            first_frame_reg <= first_frame_next;
        end
    end

endmodule

@@ hdl/lvfd_out_fifo.sv @@
// Result queue that takes up to two words a cycle and hands out one.
module lvfd_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push0,
    input  logic                push1,
    input  lvfd_pkg::out_word_t word0,
    input  lvfd_pkg::out_word_t word1,
    input  logic                pop_ready,
    output logic                out_valid,
    output lvfd_pkg::out_word_t out_word,
    output logic                room
);

    localparam int AW = lvfd_pkg::FIFO_AW;
    localparam int CW = lvfd_pkg::FIFO_CW;

    lvfd_pkg::out_word_t entry_mem [lvfd_pkg::FIFO_DEPTH];

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          pop;
    logic [CW-1:0] n_push;

    assign pop       = out_valid && pop_ready;
    assign out_valid = (count_reg != '0);
    assign out_word  = entry_mem[head_reg];
    assign room      = (count_reg <= CW'(lvfd_pkg::FIFO_DEPTH - 2));
    assign n_push    = CW'(push0) + CW'(push1);

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_mem[tail_reg] <= word0;
        end
        if (push1)
        begin
            entry_mem[tail_reg + AW'(push0)] <= word1;
        end
    end

    always_comb
    begin
        head_next  = head_reg + AW'(pop);
        tail_next  = tail_reg + AW'(n_push);
        count_next = count_reg + n_push - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/local_variance_focus_depth_map_top.sv @@
// Top level: configuration registers, raster counters and the pixel pipeline.
// A pixel word is accepted every cycle while the result queue has room; the
// row-closing word gives two result words. The result for pixel (r, c) comes with
// the word at (r+1, c+1); the queue drains one word per cycle with res_ready high.
// pix_ready is high while the four-entry result queue holds at most two words.
// Reset clears counters, window and queue; line and best stores are not cleared.
module local_variance_focus_depth_map_top #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048,
    parameter int MAX_PIXELS = 2097152
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  lvfd_pkg::in_word_t  pix_data,
    output logic                res_valid,
    input  logic                res_ready,
    output lvfd_pkg::out_word_t res_data
);

    localparam int CAW = $clog2(MAX_COLS);
    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int PAW = $clog2(MAX_PIXELS);
    localparam int LIN_RAW = $clog2(MAX_COLS * MAX_ROWS + 1);
    localparam int LINW_A = (LIN_RAW > PAW) ? LIN_RAW : PAW;
    localparam int LINW = (LINW_A > lvfd_pkg::IDX_W) ? LINW_A : lvfd_pkg::IDX_W;
    localparam int CFW = lvfd_pkg::CFG_W;

    logic [CFW-1:0]                   cols_reg;
    logic [CFW-1:0]                   rows_reg;
    logic [lvfd_pkg::FRAME_W-1:0]     first_reg;
    logic                             cfg_wr;
    logic [lvfd_pkg::REG_IDX_W-1:0]   reg_sel;
    logic                             restart;
    logic                             stack_restart;

    logic [31:0]    cols_ext;
    logic [31:0]    rows_ext;
    logic [NCW-1:0] nc;
    logic [RW-1:0]  nr;

    logic           adv;
    logic           acc;

    logic [CAW-1:0]  col_count_reg;
    logic [CAW-1:0]  col_count_next;
    logic [RW-1:0]   row_count_reg;
    logic [RW-1:0]   row_count_next;
    logic [LINW-1:0] row_base_reg;
    logic [LINW-1:0] row_base_next;
    logic [LINW-1:0] prev_base_reg;
    logic [LINW-1:0] prev_base_next;

    logic                          s0_end_row;
    logic                          s0_end_frame;
    logic [lvfd_pkg::PIX_W-1:0]    s0_pixel;
    lvfd_pkg::item_flags_t         s0_flags;
    logic [LINW-1:0]               s0_lin;

    logic                  w_valid;
    lvfd_pkg::item_flags_t w_flags;
    logic [LINW-1:0]       w_lin;
    lvfd_pkg::win_sums_t   w_sums;

    logic                push0;
    logic                push1;
    lvfd_pkg::out_word_t word0;
    lvfd_pkg::out_word_t word1;
    logic                fifo_room;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;
    assign reg_sel       = paddr[3:2];
    assign restart       = cfg_wr && (reg_sel == lvfd_pkg::REG_COLS
                                   || reg_sel == lvfd_pkg::REG_ROWS
                                   || reg_sel == lvfd_pkg::REG_FIRST);
    assign stack_restart = cfg_wr && (reg_sel == lvfd_pkg::REG_FIRST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= lvfd_pkg::COLS_RESET;
            rows_reg  <= lvfd_pkg::ROWS_RESET;
            first_reg <= lvfd_pkg::FIRST_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                lvfd_pkg::REG_COLS:  cols_reg  <= pwdata[CFW-1:0];
                lvfd_pkg::REG_ROWS:  rows_reg  <= pwdata[CFW-1:0];
                lvfd_pkg::REG_FIRST: first_reg <= pwdata[lvfd_pkg::FRAME_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            lvfd_pkg::REG_COLS:  prdata = 32'(cols_reg);
            lvfd_pkg::REG_ROWS:  prdata = 32'(rows_reg);
            lvfd_pkg::REG_FIRST: prdata = 32'(first_reg);
            default:             prdata = 32'd0;
        endcase
    end

    // Sizes outside the supported range are clamped.
    assign cols_ext = 32'(cols_reg);
    assign rows_ext = 32'(rows_reg);
    assign nc = (cols_ext < 32'd2) ? NCW'(2)
              : (cols_ext > 32'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_reg);
    assign nr = (rows_ext < 32'd2) ? RW'(2)
              : (rows_ext > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_reg);

    assign adv       = fifo_room;
    assign pix_ready = adv;
    assign acc       = pix_valid && adv;

    // Rows past the image are the drain row, whose words read as zero pixels.
    always_comb
    begin
        s0_end_row   = (NCW'(col_count_reg) + NCW'(1)) == nc;
        s0_end_frame = s0_end_row && (row_count_reg == nr);
        if (pix_data.op == lvfd_pkg::OP_PIXEL && row_count_reg < nr)
        begin
            s0_pixel = pix_data.pixel;
        end
        else
        begin
            s0_pixel = '0;
        end
        s0_flags.emit      = (row_count_reg != '0) && (col_count_reg != '0);
        s0_flags.end_row   = s0_end_row;
        s0_flags.end_frame = s0_end_frame;
        s0_flags.left_zero = (col_count_reg == CAW'(1));
        s0_flags.top_zero  = (row_count_reg == RW'(1));
        s0_lin = prev_base_reg + LINW'(col_count_reg) - LINW'(1);
    end

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        row_base_next  = row_base_reg;
        prev_base_next = prev_base_reg;
        if (restart)
        begin
            col_count_next = '0;
            row_count_next = '0;
            row_base_next  = '0;
            prev_base_next = '0;
        end
        else if (acc)
        begin
            if (s0_end_row)
            begin
                col_count_next = '0;
                if (s0_end_frame)
                begin
                    row_count_next = '0;
                    row_base_next  = '0;
                    prev_base_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + RW'(1);
                    prev_base_next = row_base_reg;
                    row_base_next  = row_base_reg + LINW'(nc);
                end
            end
            else
            begin
                col_count_next = col_count_reg + CAW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            row_base_reg  <= '0;
            prev_base_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            row_base_reg  <= row_base_next;
            prev_base_reg <= prev_base_next;
        end
    end

    lvfd_window #(
        .MAX_COLS (MAX_COLS),
        .LINW     (LINW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .restart   (restart),
        .in_valid  (acc),
        .in_col    (col_count_reg),
        .in_pixel  (s0_pixel),
        .in_flags  (s0_flags),
        .in_lin    (s0_lin),
        .out_valid (w_valid),
        .out_flags (w_flags),
        .out_lin   (w_lin),
        .out_sums  (w_sums)
    );

    lvfd_best #(
        .MAX_PIXELS (MAX_PIXELS),
        .LINW       (LINW)
    ) u_best (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .stack_restart (stack_restart),
        .first_index   (pwdata[lvfd_pkg::FRAME_W-1:0]),
        .in_valid      (w_valid),
        .in_flags      (w_flags),
        .in_lin        (w_lin),
        .in_sums       (w_sums),
        .push0         (push0),
        .push1         (push1),
        .word0         (word0),
        .word1         (word1)
    );

    lvfd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .word0     (word0),
        .word1     (word1),
        .pop_ready (res_ready),
        .out_valid (res_valid),
        .out_word  (res_data),
        .room      (fifo_room)
    );

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        NCW'(col_count_reg) < nc)
        else $error("column counter beyond the row width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= nr)
        else $error("row counter beyond the drain row");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s0_end_row && !s0_end_frame && !cfg_wr)
        |=> (row_count_reg == $past(row_count_reg) + RW'(1)) && (col_count_reg == '0))
        else $error("row end did not advance the row counter");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> push0)
        else $error("second result word without a first");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the local variance focus depth map block.
module tb_top;

    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;
    localparam int MAX_PIXELS = 2097152;
    localparam int RANDOM_WORDS = 500;
    localparam int STALL_CYCLES = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    lvfd_pkg::in_word_t    pix_data = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    lvfd_pkg::out_word_t   res_data;

    local_variance_focus_depth_map_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #10 clk = ~clk;

    logic [lvfd_pkg::CFG_W-1:0]   cols_reg = lvfd_pkg::COLS_RESET;
    logic [lvfd_pkg::CFG_W-1:0]   rows_reg = lvfd_pkg::ROWS_RESET;
    logic [lvfd_pkg::FRAME_W-1:0] frame_idx = lvfd_pkg::FIRST_RESET;
    bit                           stack_first = 1'b1;
    int                           row_pos = 0;
    int                           col_pos = 0;
    logic [lvfd_pkg::PIX_W-1:0]   line_buf [0:2*MAX_COLS-1];
    logic [lvfd_pkg::PIX_W-1:0]   win_px [0:8];
    logic [lvfd_pkg::VAR_W-1:0]   best_var [int];
    logic [lvfd_pkg::FRAME_W-1:0] best_frm [int];
    lvfd_pkg::out_word_t          expected_words [$];

    int fail_count = 0;
    int words_sent = 0;
    bit quiet = 1'b0;
    int stall_reqs = 0;
    int stall_seen = 0;
    int hold_left = 0;

    initial
    begin
        foreach (line_buf[i])
            line_buf[i] = '0;
        foreach (win_px[i])
            win_px[i] = '0;
    end

    function automatic int clamp_size(logic [lvfd_pkg::CFG_W-1:0] v, int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic int cols_used();
        return clamp_size(cols_reg, MAX_COLS);
    endfunction

    function automatic int rows_used();
        return clamp_size(rows_reg, MAX_ROWS);
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [lvfd_pkg::VAR_W-1:0] window_variance(int c0, bit left_zero,
                                                                   bit top_zero);
        int s;
        int q;
        int p;
        s = 0;
        q = 0;
        for (int r = 0; r < lvfd_pkg::WIN; r++)
            for (int k = 0; k < lvfd_pkg::WIN; k++)
                if (!(r == 0 && top_zero) && !(k == 0 && left_zero)
                    && (c0 + k < lvfd_pkg::WIN))
                begin
                    p = int'(win_px[r*lvfd_pkg::WIN + c0 + k]);
                    s += p;
                    q += p * p;
                end
        return lvfd_pkg::VAR_W'(9 * q - s * s);
    endfunction

    task automatic restart_frame();
        row_pos = 0;
        col_pos = 0;
        foreach (win_px[i])
            win_px[i] = '0;
    endtask

    task automatic store_result(int r, int c, int nc, logic [lvfd_pkg::VAR_W-1:0] v, bit last);
        longint lin;
        int addr;
        logic [lvfd_pkg::VAR_W-1:0] old;
        lvfd_pkg::out_word_t w;
        lin = longint'(r) * nc + c;
        addr = int'(lin % MAX_PIXELS);
        old = best_var.exists(addr) ? best_var[addr] : '0;
        if (stack_first || v > old)
        begin
            best_var[addr] = v;
            best_frm[addr] = frame_idx;
        end
        w.pixel_index = lin[lvfd_pkg::IDX_W-1:0];
        w.variance_scaled = v;
        w.best_frame = best_frm.exists(addr) ? best_frm[addr] : '0;
        w.frame_last = last;
        expected_words.push_back(w);
    endtask

    task automatic predict_variance(logic op, logic [lvfd_pkg::PIX_W-1:0] pix);
        int nc;
        int nr;
        int r;
        int c;
        logic [lvfd_pkg::PIX_W-1:0] p;
        logic [lvfd_pkg::PIX_W-1:0] a;
        logic [lvfd_pkg::PIX_W-1:0] b;
        bit end_row;
        bit end_frame;
        bit top;
        nc = cols_used();
        nr = rows_used();
        r = row_pos;
        c = col_pos;
        if (c >= nc)
            c = nc - 1;
        if (r > nr)
            r = nr;
        p = (op == lvfd_pkg::OP_PIXEL && r < nr) ? pix : '0;
        a = line_buf[c];
        b = line_buf[MAX_COLS + c];
        line_buf[c] = b;
        line_buf[MAX_COLS + c] = p;
        for (int i = 0; i < lvfd_pkg::WIN; i++)
        begin
            win_px[i*lvfd_pkg::WIN] = win_px[i*lvfd_pkg::WIN + 1];
            win_px[i*lvfd_pkg::WIN + 1] = win_px[i*lvfd_pkg::WIN + 2];
        end
        win_px[2] = a;
        win_px[5] = b;
        win_px[8] = p;
        end_row = (c == nc - 1);
        end_frame = end_row && (r == nr);
        if (r >= 1 && c >= 1)
        begin
            top = (r == 1);
            store_result(r - 1, c - 1, nc, window_variance(0, c == 1, top), 1'b0);
            if (end_row)
                store_result(r - 1, c, nc, window_variance(1, 1'b0, top), end_frame);
        end
        if (end_row)
        begin
            col_pos = 0;
            if (end_frame)
            begin
                row_pos = 0;
                frame_idx = frame_idx + 1'b1;
                stack_first = 1'b0;
            end
            else
                row_pos = r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic send_word(logic op, logic [lvfd_pkg::PIX_W-1:0] pix);
        while (!quiet && $urandom_range(0, 99) < 14)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data <= '{op: op, pixel: pix};
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        predict_variance(op, pix);
        words_sent++;
    endtask

    task automatic send_frame(int nc, int nr, int noise);
        for (int i = 0; i < nr * nc; i++)
            send_word(($urandom_range(0, 99) < noise) ? lvfd_pkg::OP_DRAIN : lvfd_pkg::OP_PIXEL,
                      rand_pixel());
        for (int i = 0; i < nc; i++)
            send_word(($urandom_range(0, 99) < noise) ? lvfd_pkg::OP_PIXEL : lvfd_pkg::OP_DRAIN,
                      rand_pixel());
    endtask

    task automatic wait_idle();
        int n;
        pix_valid <= 1'b0;
        n = 0;
        while (expected_words.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        if (expected_words.size() != 0)
        begin
            $display("ERROR: %0d expected result words never arrived", expected_words.size());
            fail_count += expected_words.size();
            expected_words.delete();
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic cfg_write(logic [lvfd_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lvfd_pkg::REG_COLS:
            begin
                cols_reg = value[lvfd_pkg::CFG_W-1:0];
                restart_frame();
            end
            lvfd_pkg::REG_ROWS:
            begin
                rows_reg = value[lvfd_pkg::CFG_W-1:0];
                restart_frame();
            end
            lvfd_pkg::REG_FIRST:
            begin
                frame_idx = value[lvfd_pkg::FRAME_W-1:0];
                stack_first = 1'b1;
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic cfg_stack(int nc, int nr, logic [lvfd_pkg::FRAME_W-1:0] first);
        cfg_write(lvfd_pkg::REG_COLS, 32'(nc));
        cfg_write(lvfd_pkg::REG_ROWS, 32'(nr));
        cfg_write(lvfd_pkg::REG_FIRST, 32'(first));
    endtask

    task automatic check_word(lvfd_pkg::out_word_t got);
        lvfd_pkg::out_word_t want;
        if (expected_words.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: unexpected result word idx=%0d var=%0d frame=%0d last=%0b",
                         got.pixel_index, got.variance_scaled, got.best_frame, got.frame_last);
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.pixel_index !== want.pixel_index
                || got.variance_scaled !== want.variance_scaled
                || got.best_frame !== want.best_frame
                || got.frame_last !== want.frame_last)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("MISMATCH: expected idx=%0d var=%0d frame=%0d last=%0b,",
                             want.pixel_index, want.variance_scaled, want.best_frame,
                             want.frame_last,
                             " got idx=%0d var=%0d frame=%0d last=%0b",
                             got.pixel_index, got.variance_scaled,
                             got.best_frame, got.frame_last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            check_word(res_data);
        if (stall_reqs != stall_seen)
        begin
            stall_seen = stall_reqs;
            hold_left = STALL_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < 14)
            res_ready <= 1'b0;
        else
            res_ready <= 1'b1;
    end

    // Only the start of a frame at the reset sizes: row 0 and a few words of row 1.
    task automatic test_reset_defaults();
        for (int i = 0; i < int'(lvfd_pkg::COLS_RESET) + 3; i++)
            send_word(lvfd_pkg::OP_PIXEL, rand_pixel());
        wait_idle();
    endtask

    task automatic test_corner_frames();
        cfg_write(lvfd_pkg::REG_COLS, 32'd1);
        cfg_write(lvfd_pkg::REG_ROWS, 32'd0);
        cfg_write(lvfd_pkg::REG_FIRST, 32'hFFFF);
        for (int f = 0; f < 2; f++)
        begin
            send_word(lvfd_pkg::OP_PIXEL, 8'hFF);
            send_word(lvfd_pkg::OP_PIXEL, 8'h00);
            send_word(lvfd_pkg::OP_PIXEL, 8'h00);
            send_word(lvfd_pkg::OP_PIXEL, 8'hFF);
            send_word(lvfd_pkg::OP_PIXEL, 8'hC8);
            send_word(lvfd_pkg::OP_DRAIN, 8'hA5);
        end
        send_word(lvfd_pkg::OP_PIXEL, 8'hFF);
        send_word(lvfd_pkg::OP_DRAIN, 8'h5A);
        send_word(lvfd_pkg::OP_PIXEL, 8'h00);
        send_word(lvfd_pkg::OP_PIXEL, 8'hFF);
        send_word(lvfd_pkg::OP_DRAIN, 8'h00);
        send_word(lvfd_pkg::OP_DRAIN, 8'hFF);
        wait_idle();
    endtask

    task automatic test_backpressure();
        cfg_stack(8, 6, 16'($urandom_range(0, 65535)));
        quiet = 1'b1;
        stall_reqs++;
        send_frame(8, 6, 0);
        send_frame(8, 6, 0);
        wait_idle();
        quiet = 1'b0;
    endtask

    task automatic test_random_stacks();
        int start;
        int nframes;
        bit have_stack;
        start = words_sent;
        have_stack = 1'b0;
        while (words_sent - start < RANDOM_WORDS)
        begin
            if (have_stack && $urandom_range(0, 9) < 2)
                cfg_write(lvfd_pkg::REG_COLS, 32'($urandom_range(2, cols_used())));
            else
            begin
                cfg_stack($urandom_range(2, 12), $urandom_range(2, 8),
                          ($urandom_range(0, 9) == 0) ? 16'hFFFE
                                                      : 16'($urandom_range(0, 65535)));
                have_stack = 1'b1;
            end
            quiet = ($urandom_range(0, 3) == 0);
            nframes = $urandom_range(1, 4);
            for (int f = 0; f < nframes; f++)
                if ($urandom_range(0, 9) == 0)
                begin
                    for (int i = $urandom_range(1, (rows_used() + 1) * cols_used() - 1);
                         i > 0; i--)
                        send_word(($urandom_range(0, 99) < 5) ? lvfd_pkg::OP_DRAIN
                                                              : lvfd_pkg::OP_PIXEL,
                                  rand_pixel());
                end
                else
                    send_frame(cols_used(), rows_used(), 5);
            wait_idle();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_defaults();
        test_corner_frames();
        test_backpressure();
        test_random_stacks();
        wait_idle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lvfd_pkg.sv
hdl/lvfd_window.sv
hdl/lvfd_best.sv
hdl/lvfd_out_fifo.sv
hdl/local_variance_focus_depth_map_top.sv
sim/tb_top.sv
